// ===== sv/insertion_sorter_with_readout_assert.svh =====
// Assertion macros for the sorter RTL.
`ifndef INSERTION_SORTER_WITH_READOUT_ASSERT_SVH
`define INSERTION_SORTER_WITH_READOUT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ISR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ISR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/isr_pkg.sv =====
// Package with types and constants of the insertion sorter.
`timescale 1ns / 1ps

package isr_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_ASC    = 2'd1,
    REQ_DESC   = 2'd2,
    REQ_CLEAR  = 2'd3
  } isr_req_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROT_DN,
    CELL_ROT_UP
  } isr_cell_op_t;

  typedef struct packed {
    isr_req_t                  req_type;
    logic signed [DATA_W-1:0]  value;
  } isr_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  data;
    logic                      last;
    logic                      empty_res;
    logic                      overflowed;
  } isr_out_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    isr_cell_op_t              op;
    logic signed [DATA_W-1:0]  new_val;
    logic signed [DATA_W-1:0]  wrap_val;
  } isr_cell_ctl_t;

  // Where a cell sits relative to the fill level.
  typedef struct packed {
    logic occ;
    logic at_cnt;
    logic at_tail;
  } isr_cell_pos_t;

endpackage

// ===== sv/isr_cell.sv =====
// One storage cell of the sorting chain.
`timescale 1ns / 1ps

module isr_cell (
  input  logic                                  clk,
  input  isr_pkg::isr_cell_ctl_t                ctl_i,
  input  isr_pkg::isr_cell_pos_t                pos_i,
  input  logic signed [isr_pkg::DATA_W-1:0]     left_val_i,
  input  logic                                  left_gt_i,
  input  logic signed [isr_pkg::DATA_W-1:0]     right_val_i,
  output logic signed [isr_pkg::DATA_W-1:0]     val_o,
  output logic                                  gt_o
);

  logic signed [isr_pkg::DATA_W-1:0] val_r;
  logic signed [isr_pkg::DATA_W-1:0] val_nxt;

  // The stored value is larger than the new one, so it must move up.
  assign gt_o  = pos_i.occ && (ctl_i.new_val < val_r);
  assign val_o = val_r;

  always_comb begin
    val_nxt = val_r;
    unique case (ctl_i.op)
      isr_pkg::CELL_INSERT: begin
        if (left_gt_i) begin
          val_nxt = left_val_i;
        end else if (gt_o || pos_i.at_cnt) begin
          val_nxt = ctl_i.new_val;
        end
      end
      isr_pkg::CELL_ROT_DN: begin
        if (pos_i.occ) begin
          val_nxt = pos_i.at_tail ? ctl_i.wrap_val : right_val_i;
        end
      end
      isr_pkg::CELL_ROT_UP: begin
        if (pos_i.occ) begin
          val_nxt = left_val_i;
        end
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== sv/insertion_sorter_with_readout.sv =====
// Top level of the insertion sorter: cell chain, fill count and readout sequencer.
`timescale 1ns / 1ps
// Usage:
// The input channel (in_valid, in_ready, in_data) takes requests: insert a
// signed value, read ascending, read descending, or clear the store.
// Inserts and clears produce no transaction on the output channel. An insert
// is taken every cycle while no readout is busy: all cells compare against
// the new value at once and the larger entries move up one cell in the same
// cycle. An insert into a full store is dropped and sets the sticky
// overflowed flag. A readout streams every stored value through the output
// channel (out_valid, out_ready, out_data), one per cycle, with last on the
// final value; the request sets the busy flag, and each value is then loaded
// into the output register. An empty store gives a single transaction with
// empty_res set. The chain rotates by one cell per value, and in_ready stays
// low until the last value is loaded into the output register. When the
// receiver stalls, the output register holds its value and the rotation
// waits. Reset empties the store and clears the overflow flag; the cell
// contents themselves are not reset.
`include "insertion_sorter_with_readout_assert.svh"

module insertion_sorter_with_readout (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  isr_pkg::isr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output isr_pkg::isr_out_t out_data
);

  localparam int DEPTH  = isr_pkg::DEPTH;
  localparam int DATA_W = isr_pkg::DATA_W;
  localparam int CNT_W  = isr_pkg::CNT_W;

  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     ovf_r, ovf_nxt;
  logic                     busy_r, busy_nxt;
  logic                     desc_r, desc_nxt;
  logic [CNT_W-1:0]         idx_r, idx_nxt;
  logic                     out_valid_r, out_valid_nxt;
  isr_pkg::isr_out_t        out_r, out_nxt;

  isr_pkg::isr_cell_ctl_t   ctl;
  isr_pkg::isr_cell_pos_t   pos  [DEPTH];
  logic signed [DATA_W-1:0] cval [DEPTH];
  logic                     cgt  [DEPTH];
  logic signed [DATA_W-1:0] tail_val;
  logic signed [DATA_W-1:0] head_val;
  logic [CNT_W-1:0]         cnt_m1;
  logic                     in_fire;
  logic                     emit;
  logic                     is_empty;

  assign in_ready  = !busy_r;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign emit      = busy_r && (!out_valid_r || out_ready);
  assign is_empty  = (cnt_r == '0);
  assign cnt_m1    = cnt_r - CNT_W'(1);
  assign head_val  = cval[0];

  // Largest stored entry, picked with a one-hot mask on the tail cell.
  always_comb begin
    tail_val = '0;
    for (int k = 0; k < DEPTH; k++) begin
      tail_val = tail_val | (cval[k] & {DATA_W{pos[k].at_tail}});
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic signed [DATA_W-1:0] left_val;
      logic                     left_gt;
      logic signed [DATA_W-1:0] right_val;

      assign pos[gi].occ     = (CNT_W'(gi) < cnt_r);
      assign pos[gi].at_cnt  = (CNT_W'(gi) == cnt_r);
      assign pos[gi].at_tail = (CNT_W'(gi) == cnt_m1) && !is_empty;

      if (gi == 0) begin : g_head
        assign left_val = ctl.wrap_val;
        assign left_gt  = 1'b0;
      end else begin : g_body
        assign left_val = cval[gi-1];
        assign left_gt  = cgt[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_end
        assign right_val = ctl.wrap_val;
      end else begin : g_mid
        assign right_val = cval[gi+1];
      end

      isr_cell u_cell (
        .clk         (clk),
        .ctl_i       (ctl),
        .pos_i       (pos[gi]),
        .left_val_i  (left_val),
        .left_gt_i   (left_gt),
        .right_val_i (right_val),
        .val_o       (cval[gi]),
        .gt_o        (cgt[gi])
      );
    end
  endgenerate

  always_comb begin
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    busy_nxt      = busy_r;
    desc_nxt      = desc_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    ctl.op        = isr_pkg::CELL_HOLD;
    ctl.new_val   = in_data.value;
    ctl.wrap_val  = desc_r ? tail_val : head_val;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_fire) begin
      unique case (in_data.req_type) inside
        isr_pkg::REQ_INSERT: begin
          if (cnt_r == CNT_W'(DEPTH)) begin
            ovf_nxt = 1'b1;
          end else begin
            ctl.op  = isr_pkg::CELL_INSERT;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        isr_pkg::REQ_ASC, isr_pkg::REQ_DESC: begin
          busy_nxt = 1'b1;
          desc_nxt = (in_data.req_type == isr_pkg::REQ_DESC);
          idx_nxt  = '0;
        end
        isr_pkg::REQ_CLEAR: begin
          cnt_nxt = '0;
        end
        default: begin
          cnt_nxt = cnt_r;
        end
      endcase
    end

    if (emit) begin
      out_valid_nxt       = 1'b1;
      out_nxt.overflowed  = ovf_r;
      if (is_empty) begin
        out_nxt.data      = '0;
        out_nxt.last      = 1'b1;
        out_nxt.empty_res = 1'b1;
        busy_nxt          = 1'b0;
      end else begin
        out_nxt.data      = desc_r ? tail_val : head_val;
        out_nxt.last      = (idx_r == cnt_m1);
        out_nxt.empty_res = 1'b0;
        ctl.op            = desc_r ? isr_pkg::CELL_ROT_UP : isr_pkg::CELL_ROT_DN;
        idx_nxt           = idx_r + CNT_W'(1);
        if (idx_r == cnt_m1) begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      busy_r      <= 1'b0;
      desc_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      busy_r      <= busy_nxt;
      desc_r      <= desc_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  `ISR_ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= CNT_W'(DEPTH), "count above depth")
  `ISR_ASSERT_NEXT(a_cnt_stable, clk, rst_n, busy_r, cnt_r == $past(cnt_r), "count moved")
  `ISR_ASSERT_NEXT(a_ovf_sticky, clk, rst_n, ovf_r, ovf_r, "overflow flag cleared")
  `ISR_ASSERT_IMPL(a_empty_last, clk, rst_n, out_valid_r && out_r.empty_res, out_r.last,
    "empty result without last")

endmodule
